>>> rtl/core/phfd_pkg.sv
// Shared types and constants for the four-digit polynomial hash.
// No dependencies.
package phfd_pkg;

    localparam int unsigned HASH_PRIME  = 9973;
    localparam int unsigned FACTOR_SHFT = 5;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WEIGHT_W    = 14;
    localparam int unsigned HASH_W      = 15;
    localparam int unsigned MAG_W       = 14;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned QUOT_W      = 8;
    localparam int unsigned QUOT_BIAS   = 128;
    localparam int unsigned PROD_W      = 22;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP_W     = 19;

    localparam logic [PROD_W-1:0]  PROD_OFFSET = PROD_W'(QUOT_BIAS * HASH_PRIME);
    localparam logic [RECIP_W-1:0] RECIP_MUL   =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(HASH_PRIME));

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              is_last;
    } t_in_beat;

    typedef struct packed {
        logic [MAG_W-1:0]   hash_magnitude;
        logic [DIGIT_W-1:0] digit_thousands;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_ones;
    } t_out_beat;

    typedef struct packed {
        logic valid;
        logic has_byte;
        logic is_last;
    } t_ctrl;

    // floor split of the biased product: quot * prime + rem
    typedef struct packed {
        logic [QUOT_W-1:0]   quot;
        logic [WEIGHT_W-1:0] rem;
    } t_floor;

endpackage

>>> rtl/core/polynomial_hash_four_digit_top.sv
// Top level of the four-digit polynomial hash over signed message bytes.
// Depends on phfd_pkg, phfd_reduce and phfd_digits.
//
// Takes one beat per clock while not stalled and gives the result of a
// message once its last beat has passed the input, reduction, hash and
// digit registers. The whole pipeline advances together and holds only
// while the output register is full and not taken. Products and their
// reduction by the prime run ahead of the hash register, so the only loops
// are the input weight update and the compare-and-select hash update.
module polynomial_hash_four_digit_top
    import phfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    function automatic logic [WEIGHT_W-1:0] weight_step(input logic [WEIGHT_W-1:0] w);
        logic [WEIGHT_W:0]   x;
        logic [WEIGHT_W+1:0] y;
        x = {1'b0, w};
        for (int i = 0; i < FACTOR_SHFT; i++) begin
            x = x << 1;
            if (x >= (WEIGHT_W+1)'(HASH_PRIME)) begin
                x = x - (WEIGHT_W+1)'(HASH_PRIME);
            end
        end
        y = {1'b0, x} - {2'b0, w};
        if (y[WEIGHT_W+1]) begin
            y = y + (WEIGHT_W+2)'(HASH_PRIME);
        end
        return y[WEIGHT_W-1:0];
    endfunction

    logic                       en;
    logic [WEIGHT_W-1:0]        r_weight;
    logic signed [HASH_W-1:0]   r_hash;
    t_ctrl                      r0_ctrl;
    logic [BYTE_W-1:0]          r0_byte;
    logic [WEIGHT_W-1:0]        r0_weight;
    logic                       r4_valid;
    logic [MAG_W-1:0]           r4_mag;

    t_ctrl                      red_ctrl;
    t_floor                     red_floor;

    logic signed [HASH_W:0]     sum_t;
    logic [WEIGHT_W-1:0]        canon;
    logic                       neg;
    logic signed [HASH_W-1:0]   upd_hash, n_hash;
    logic [MAG_W-1:0]           n_mag;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    phfd_reduce u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctrl   (r0_ctrl),
        .i_byte   (r0_byte),
        .i_weight (r0_weight),
        .o_ctrl   (red_ctrl),
        .o_floor  (red_floor)
    );

    // sum = (quot - bias)*prime + (hash + rem); sign of sum comes from quot and t
    assign sum_t = {r_hash[HASH_W-1], r_hash} + $signed({2'b0, red_floor.rem});

    always_comb begin
        if (sum_t < 0) begin
            canon = WEIGHT_W'(sum_t + (HASH_W+1)'(HASH_PRIME));
        end else if (sum_t >= (HASH_W+1)'(HASH_PRIME)) begin
            canon = WEIGHT_W'(sum_t - (HASH_W+1)'(HASH_PRIME));
        end else begin
            canon = WEIGHT_W'(sum_t);
        end

        if (red_floor.quot > QUOT_W'(QUOT_BIAS)) begin
            neg = 1'b0;
        end else if (red_floor.quot == QUOT_W'(QUOT_BIAS)) begin
            neg = sum_t < 0;
        end else if (red_floor.quot == QUOT_W'(QUOT_BIAS - 1)) begin
            neg = sum_t < $signed((HASH_W+1)'(HASH_PRIME));
        end else begin
            neg = 1'b1;
        end

        if (neg && canon != '0) begin
            upd_hash = $signed({1'b0, canon}) - $signed(HASH_W'(HASH_PRIME));
        end else begin
            upd_hash = $signed({1'b0, canon});
        end

        n_hash = red_ctrl.has_byte ? upd_hash : r_hash;
        n_mag  = n_hash[HASH_W-1] ? MAG_W'(-n_hash) : MAG_W'(n_hash);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_W'(1);
            r_hash   <= '0;
            r0_ctrl  <= '0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r0_ctrl.valid    <= i_in_valid;
            r0_ctrl.has_byte <= i_in_data.has_byte;
            r0_ctrl.is_last  <= i_in_data.is_last;
            if (i_in_valid) begin
                if (i_in_data.is_last) begin
                    r_weight <= WEIGHT_W'(1);
                end else if (i_in_data.has_byte) begin
                    r_weight <= weight_step(r_weight);
                end
            end
            r4_valid <= red_ctrl.valid && red_ctrl.is_last;
            if (red_ctrl.valid) begin
                r_hash <= red_ctrl.is_last ? '0 : n_hash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_byte   <= i_in_data.data_byte;
            r0_weight <= r_weight;
            r4_mag    <= n_mag;
        end
    end

    phfd_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_valid),
        .i_mag   (r4_mag),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

>>> rtl/core/phfd_reduce.sv
// Byte-times-weight product and its floor split by the prime, three stages.
// Depends on phfd_pkg.
module phfd_reduce
    import phfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_ctrl               i_ctrl,
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic [WEIGHT_W-1:0] i_weight,
    output t_ctrl               o_ctrl,
    output t_floor              o_floor
);

    localparam int unsigned SCALE_W = PROD_W + RECIP_W;

    t_ctrl                 r1_ctrl, r2_ctrl, r3_ctrl;
    logic [PROD_W-1:0]     r1_biased, r2_biased;
    logic [QUOT_W-1:0]     r2_quot;
    t_floor                r3_floor;

    logic signed [PROD_W-1:0] byte_ext, weight_ext, prod;
    logic [PROD_W-1:0]        n_biased;
    logic [SCALE_W-1:0]       scaled;
    logic [PROD_W-1:0]        sub, rest;
    t_floor                   n_floor;

    assign byte_ext   = {{(PROD_W-BYTE_W){i_byte[BYTE_W-1]}}, i_byte};
    assign weight_ext = {{(PROD_W-WEIGHT_W){1'b0}}, i_weight};
    assign prod       = byte_ext * weight_ext;
    assign n_biased   = $unsigned(prod) + PROD_OFFSET;

    assign scaled = SCALE_W'(r1_biased) * SCALE_W'(RECIP_MUL);

    assign sub  = PROD_W'(r2_quot) * PROD_W'(HASH_PRIME);
    assign rest = r2_biased - sub;

    // estimate is exact or one low
    always_comb begin
        if (rest >= PROD_W'(HASH_PRIME)) begin
            n_floor.quot = r2_quot + QUOT_W'(1);
            n_floor.rem  = WEIGHT_W'(rest - PROD_W'(HASH_PRIME));
        end else begin
            n_floor.quot = r2_quot;
            n_floor.rem  = WEIGHT_W'(rest);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl <= '0;
            r2_ctrl <= '0;
            r3_ctrl <= '0;
        end else if (i_en) begin
            r1_ctrl <= i_ctrl;
            r2_ctrl <= r1_ctrl;
            r3_ctrl <= r2_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_biased <= n_biased;
            r2_biased <= r1_biased;
            r2_quot   <= scaled[RECIP_SHIFT +: QUOT_W];
            r3_floor  <= n_floor;
        end
    end

    assign o_ctrl  = r3_ctrl;
    assign o_floor = r3_floor;

endmodule

>>> rtl/core/phfd_digits.sv
// Decimal digit split of the hash magnitude, three stages; last stage is the
// output register. Depends on phfd_pkg.
module phfd_digits
    import phfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [MAG_W-1:0] i_mag,
    output logic             o_valid,
    output t_out_beat        o_data
);

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [MAG_W-1:0]   rest;
    } t_digit;

    function automatic t_digit digit_split(input logic [MAG_W-1:0] value,
                                           input int unsigned unit);
        t_digit res;
        res.digit = '0;
        res.rest  = value;
        for (int k = 1; k <= 9; k++) begin
            if (value >= MAG_W'(k * unit)) begin
                res.digit = DIGIT_W'(k);
                res.rest  = value - MAG_W'(k * unit);
            end
        end
        return res;
    endfunction

    logic               r5_valid, r6_valid, r7_valid;
    logic [MAG_W-1:0]   r5_mag, r6_mag;
    logic [DIGIT_W-1:0] r5_th, r6_th, r6_hu;
    logic [9:0]         r5_rest;
    logic [6:0]         r6_rest;
    t_out_beat          r7_data;

    t_digit th, hu, te;

    assign th = digit_split(i_mag, 1000);
    assign hu = digit_split(MAG_W'(r5_rest), 100);
    assign te = digit_split(MAG_W'(r6_rest), 10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= i_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_mag                  <= i_mag;
            r5_th                   <= th.digit;
            r5_rest                 <= th.rest[9:0];
            r6_mag                  <= r5_mag;
            r6_th                   <= r5_th;
            r6_hu                   <= hu.digit;
            r6_rest                 <= hu.rest[6:0];
            r7_data.hash_magnitude  <= r6_mag;
            r7_data.digit_thousands <= r6_th;
            r7_data.digit_hundreds  <= r6_hu;
            r7_data.digit_tens      <= te.digit;
            r7_data.digit_ones      <= te.rest[DIGIT_W-1:0];
        end
    end

    assign o_valid = r7_valid;
    assign o_data  = r7_data;

endmodule

>>> rtl/core/phfd_checker.sv
// Port-level checks for the four-digit polynomial hash, bound to the top level.
// Depends on phfd_pkg.
module phfd_checker
    import phfd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.digit_thousands <= DIGIT_W'(9)
            && o_out_data.digit_hundreds <= DIGIT_W'(9)
            && o_out_data.digit_tens <= DIGIT_W'(9)
            && o_out_data.digit_ones <= DIGIT_W'(9))
        else $error("digit out of range");

    a_digit_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.hash_magnitude) ==
            32'(o_out_data.digit_thousands) * 32'd1000
            + 32'(o_out_data.digit_hundreds) * 32'd100
            + 32'(o_out_data.digit_tens) * 32'd10
            + 32'(o_out_data.digit_ones))
        else $error("digits disagree with magnitude");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.hash_magnitude < MAG_W'(HASH_PRIME))
        else $error("magnitude not below prime");

endmodule

bind polynomial_hash_four_digit_top phfd_checker u_checker (.*);
